>>> sv/tbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types and constants for the thresholded bounding box and centroid
// block: field types, the controller states, the command bundle and the result beat.
// ----------------------------------------------------------------------------
package tbc_pkg;

    // Field widths fixed by the interface definition.
    localparam int FRAC_W  = 17;
    localparam int POS_W   = 32;
    localparam int COUNT_W = 21;

    // Fill threshold after reset, one half in Q1.16.
    localparam logic [FRAC_W-1:0] THRESH_RESET = 17'd32768;

    // Empty-set sentinels for the bounding box.
    localparam logic signed [POS_W-1:0] POS_MOST_POS = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MOST_NEG = 32'sh8000_0000;

    typedef logic [FRAC_W-1:0]         t_frac;
    typedef logic signed [POS_W-1:0]   t_pos;
    typedef logic [COUNT_W-1:0]        t_count;

    // Axis codes, also the index into the per-axis arrays.
    typedef logic [1:0] t_axis;
    localparam t_axis AXIS_X = 2'd0;
    localparam t_axis AXIS_Y = 2'd1;
    localparam t_axis AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DIVIDE,
        ST_HOLD
    } t_ctrl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  acc;        // an input beat is accepted this cycle
        logic  clear;      // return the running state to its empty values
        logic  div_load;   // load the divider with the sum of the chosen axis
        logic  div_step;   // one quotient bit
        logic  div_store;  // write the signed quotient to the chosen axis
        logic  out_load;   // copy the finished result into the output register
        t_axis axis;
    } t_dp_cmd;

    // One result beat.
    typedef struct packed {
        t_pos   box_min_x;
        t_pos   box_max_x;
        t_pos   box_min_y;
        t_pos   box_max_y;
        t_pos   box_min_z;
        t_pos   box_max_z;
        t_pos   mean_x;
        t_pos   mean_y;
        t_pos   mean_z;
        t_count points_counted;
    } t_result;

endpackage
`default_nettype wire

>>> sv/tbc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbc_if
// Valid/ready channels of the block: the point stream and the result stream.
// ----------------------------------------------------------------------------
interface tbc_pt_if;
    import tbc_pkg::*;

    logic  valid;
    logic  ready;
    t_frac fill_fraction;
    t_pos  pos_x;
    t_pos  pos_y;
    t_pos  pos_z;
    logic  last_point;

    modport source (output valid, output fill_fraction, output pos_x, output pos_y,
                    output pos_z, output last_point, input ready);
    modport sink   (input valid, input fill_fraction, input pos_x, input pos_y,
                    input pos_z, input last_point, output ready);
endinterface

interface tbc_res_if;
    import tbc_pkg::*;

    logic   valid;
    logic   ready;
    t_pos   box_min_x;
    t_pos   box_max_x;
    t_pos   box_min_y;
    t_pos   box_max_y;
    t_pos   box_min_z;
    t_pos   box_max_z;
    t_pos   mean_x;
    t_pos   mean_y;
    t_pos   mean_z;
    t_count points_counted;

    modport source (output valid, output box_min_x, output box_max_x,
                    output box_min_y, output box_max_y, output box_min_z,
                    output box_max_z, output mean_x, output mean_y, output mean_z,
                    output points_counted, input ready);
    modport sink   (input valid, input box_min_x, input box_max_x,
                    input box_min_y, input box_max_y, input box_min_z,
                    input box_max_z, input mean_x, input mean_y, input mean_z,
                    input points_counted, output ready);
endinterface
`default_nettype wire

>>> sv/tbc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbc_ctrl
// Controller: accepts points, sequences the shared divider over the three
// axes and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module tbc_ctrl #(
    parameter int SUM_W = 52
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_pt_valid,
    input  wire logic            i_pt_last,
    output logic                 o_pt_ready,
    input  wire logic            i_res_ready,
    output logic                 o_res_valid,
    output tbc_pkg::t_dp_cmd     o_cmd
);
    import tbc_pkg::*;

    // Each axis takes a load step, then SUM_W quotient bit steps, then a store step.
    localparam int STEP_W = $clog2(SUM_W + 2);
    localparam logic [STEP_W-1:0] STORE_STEP = STEP_W'(SUM_W + 1);

    t_ctrl_state       r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    t_axis             r_axis, n_axis;
    logic              r_res_valid, n_res_valid;

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCUM;
            r_step      <= '0;
            r_axis      <= AXIS_X;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_axis      <= n_axis;
            r_res_valid <= n_res_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_axis     = r_axis;
        o_pt_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.axis = r_axis;
        unique case (r_state)
            ST_ACCUM: begin
                o_pt_ready = 1'b1;
                o_cmd.acc  = i_pt_valid;
                if (i_pt_valid && i_pt_last) begin
                    n_state = ST_DIVIDE;
                    n_step  = '0;
                    n_axis  = AXIS_X;
                end
            end
            ST_DIVIDE: begin
                if (r_step == '0) begin
                    o_cmd.div_load = 1'b1;
                end else if (r_step == STORE_STEP) begin
                    o_cmd.div_store = 1'b1;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
                if (r_step == STORE_STEP) begin
                    n_step = '0;
                    if (r_axis == AXIS_Z) begin
                        n_state = ST_HOLD;
                    end else begin
                        n_axis = r_axis + 2'd1;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_HOLD: begin
                // Wait until the output register is free or is being emptied.
                if (!r_res_valid || i_res_ready) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_state        = ST_ACCUM;
                end
            end
            default: begin
                n_state = ST_ACCUM;
            end
        endcase
    end

    // Output beat valid: set on load, dropped once the beat is taken.
    always_comb begin
        if (o_cmd.out_load) begin
            n_res_valid = 1'b1;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end else begin
            n_res_valid = r_res_valid;
        end
    end

    assign o_res_valid = r_res_valid;

endmodule
`default_nettype wire

>>> sv/tbc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbc_datapath
// Datapath: threshold register, running box, sums and count, a shared
// restoring divider for the means, and the output register.
// ----------------------------------------------------------------------------
module tbc_datapath #(
    parameter int MAX_POINTS = 1048576,
    parameter int SUM_W      = 52,
    parameter int CNT_W      = 21
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire tbc_pkg::t_frac   i_cfg_wr_data,
    input  wire tbc_pkg::t_dp_cmd i_cmd,
    input  wire tbc_pkg::t_frac   i_fill_fraction,
    input  wire tbc_pkg::t_pos    i_pos_x,
    input  wire tbc_pkg::t_pos    i_pos_y,
    input  wire tbc_pkg::t_pos    i_pos_z,
    output tbc_pkg::t_result      o_result
);
    import tbc_pkg::*;

    t_frac                   r_thresh;
    t_pos                    r_min [3];
    t_pos                    r_max [3];
    logic signed [SUM_W-1:0] r_sum [3];
    logic [CNT_W-1:0]        r_count;
    logic [SUM_W-1:0]        r_mag;
    logic [CNT_W-1:0]        r_rem;
    logic                    r_neg;
    t_pos                    r_mean [3];
    t_result                 r_result;

    t_pos                    pos_in [3];
    logic                    hit;
    logic                    can_add;
    logic signed [SUM_W-1:0] sum_sel;
    logic [CNT_W:0]          rem_sh;
    logic                    rem_ge;
    logic [CNT_W:0]          rem_sub;
    logic [SUM_W-1:0]        quot;
    logic [CNT_W+COUNT_W-1:0] count_ext;
    logic                    count_zero;

    assign pos_in[0] = i_pos_x;
    assign pos_in[1] = i_pos_y;
    assign pos_in[2] = i_pos_z;

    // A point counts when its fraction is strictly above the threshold.
    assign hit     = i_cmd.acc && (i_fill_fraction > r_thresh);
    assign can_add = r_count < CNT_W'(MAX_POINTS);

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_wr_en) begin
            r_thresh <= i_cfg_wr_data;
        end
    end

    // Running box and sums; minimum and maximum are tracked independently.
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            if (!i_rst_n || i_cmd.clear) begin
                r_min[a] <= POS_MOST_POS;
                r_max[a] <= POS_MOST_NEG;
                r_sum[a] <= '0;
            end else if (hit) begin
                if (pos_in[a] < r_min[a]) begin
                    r_min[a] <= pos_in[a];
                end
                if (pos_in[a] > r_max[a]) begin
                    r_max[a] <= pos_in[a];
                end
                if (can_add) begin
                    r_sum[a] <= r_sum[a] + SUM_W'(pos_in[a]);
                end
            end
        end
    end

    // Point count, which saturates at the set limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count <= '0;
        end else if (hit && can_add) begin
            r_count <= r_count + 1'b1;
        end
    end

    // Restoring divider on the magnitude, one quotient bit a cycle.
    assign sum_sel = r_sum[i_cmd.axis];
    assign rem_sh  = {r_rem, r_mag[SUM_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_count};
    assign rem_sub = rem_sh - {1'b0, r_count};
    assign quot    = r_neg ? (~r_mag + 1'b1) : r_mag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_neg <= sum_sel[SUM_W-1];
            r_mag <= sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_mag <= {r_mag[SUM_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
    end

    // Quotient for the chosen axis, kept to the coordinate width.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            r_mean[i_cmd.axis] <= quot[POS_W-1:0];
        end
    end

    // Output register; an empty set reports a zero centroid.
    assign count_ext  = {{COUNT_W{1'b0}}, r_count};
    assign count_zero = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_result.box_min_x      <= r_min[AXIS_X];
            r_result.box_max_x      <= r_max[AXIS_X];
            r_result.box_min_y      <= r_min[AXIS_Y];
            r_result.box_max_y      <= r_max[AXIS_Y];
            r_result.box_min_z      <= r_min[AXIS_Z];
            r_result.box_max_z      <= r_max[AXIS_Z];
            r_result.mean_x         <= count_zero ? '0 : r_mean[AXIS_X];
            r_result.mean_y         <= count_zero ? '0 : r_mean[AXIS_Y];
            r_result.mean_z         <= count_zero ? '0 : r_mean[AXIS_Z];
            r_result.points_counted <= count_ext[COUNT_W-1:0];
        end
    end

    assign o_result = r_result;

endmodule
`default_nettype wire

>>> sv/thresholded_bbox_centroid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thresholded_bbox_centroid
// Bounding box, mean position and count of the points of a set whose fill
// fraction lies above a programmable threshold.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake      Beat contents
//  i_pt      in         valid/ready    fill_fraction, pos_x/y/z, last_point
//  o_res     out        valid/ready    box min/max x/y/z, mean x/y/z, count
//  i_cfg     in         write enable   fill_threshold (17 bit)
//
//  Points are taken back to back while a set accumulates. After the last point
//  of a set the one restoring divider forms the three means in turn, a quotient
//  bit a cycle; no point is taken meanwhile.
//  The result waits in an output register while the next set accumulates.
//  Reset is synchronous and active low; the threshold returns to one half.
//  A stalled result beat holds; a second set's result waits until it is taken.
// ----------------------------------------------------------------------------
module thresholded_bbox_centroid #(
    parameter int MAX_POINTS = 1048576
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    tbc_pt_if.sink               i_pt,
    tbc_res_if.source            o_res,
    input  wire logic            i_cfg_wr_en,
    input  wire tbc_pkg::t_frac  i_cfg_wr_data
);
    import tbc_pkg::*;

    // Sum width holds MAX_POINTS coordinates; the count holds MAX_POINTS.
    localparam int SUM_W = POS_W + $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    t_dp_cmd cmd;
    t_result result;

    tbc_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pt_valid  (i_pt.valid),
        .i_pt_last   (i_pt.last_point),
        .o_pt_ready  (i_pt.ready),
        .i_res_ready (o_res.ready),
        .o_res_valid (o_res.valid),
        .o_cmd       (cmd)
    );

    tbc_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .SUM_W      (SUM_W),
        .CNT_W      (CNT_W)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_cmd           (cmd),
        .i_fill_fraction (i_pt.fill_fraction),
        .i_pos_x         (i_pt.pos_x),
        .i_pos_y         (i_pt.pos_y),
        .i_pos_z         (i_pt.pos_z),
        .o_result        (result)
    );

    // Result beat payload.
    assign o_res.box_min_x      = result.box_min_x;
    assign o_res.box_max_x      = result.box_max_x;
    assign o_res.box_min_y      = result.box_min_y;
    assign o_res.box_max_y      = result.box_max_y;
    assign o_res.box_min_z      = result.box_min_z;
    assign o_res.box_max_z      = result.box_max_z;
    assign o_res.mean_x         = result.mean_x;
    assign o_res.mean_y         = result.mean_y;
    assign o_res.mean_z         = result.mean_z;
    assign o_res.points_counted = result.points_counted;

endmodule
`default_nettype wire

>>> sv/tbc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbc_checker
// Port-level checks of the point and result streams, bound to the top level.
// ----------------------------------------------------------------------------
module tbc_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_pt_valid,
    input wire logic          i_pt_ready,
    input wire logic          i_pt_last,
    input wire logic          i_res_valid,
    input wire logic          i_res_ready,
    input wire logic signed [31:0] i_min_x,
    input wire logic signed [31:0] i_max_x,
    input wire logic signed [31:0] i_mean_x,
    input wire logic signed [31:0] i_mean_y,
    input wire logic signed [31:0] i_mean_z,
    input wire logic [20:0]   i_count
);

    // A stalled result beat keeps its valid, its x minimum, its x mean and its count.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_min_x) && $stable(i_mean_x) && $stable(i_count)))
        else $error("result beat changed while stalled");

    // The last point of a set starts the divide, so no point is taken next.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pt_valid && i_pt_ready && i_pt_last) |=> !i_pt_ready)
        else $error("point accepted during the divide");

    // An empty set reports a zero centroid and the inverted sentinel box on x.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && (i_count == '0)) |->
            ((i_mean_x == '0) && (i_mean_y == '0) && (i_mean_z == '0) &&
             (i_min_x == 32'sh7FFF_FFFF) && (i_max_x == 32'sh8000_0000)))
        else $error("empty set result wrong");

    // A non-empty set has its x mean inside the x extent of its box.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && (i_count != '0)) |->
            ((i_min_x <= i_mean_x) && (i_mean_x <= i_max_x)))
        else $error("mean outside the bounding box");

endmodule

bind thresholded_bbox_centroid tbc_checker u_tbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pt_valid  (i_pt.valid),
    .i_pt_ready  (i_pt.ready),
    .i_pt_last   (i_pt.last_point),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_min_x     (o_res.box_min_x),
    .i_max_x     (o_res.box_max_x),
    .i_mean_x    (o_res.mean_x),
    .i_mean_y    (o_res.mean_y),
    .i_mean_z    (o_res.mean_z),
    .i_count     (o_res.points_counted)
);
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for thresholded_bbox_centroid. Points are streamed in
// sets through the valid/ready input channel. A bench-side model keeps the
// running box, sums and count, and forms the summary that each closing point
// should produce. The summaries that the block returns are compared field by
// field, in order, while each channel idles or stalls at random in the phases that enable it.
// ----------------------------------------------------------------------------
module tb;
    import tbc_pkg::*;

    // Point limit of the block, the same as its default.
    localparam int PT_LIMIT = 1048576;
    // Cycles to let pass after the last summary before reprogramming or ending.
    localparam int HOLD_OFF = 200;
    // Cycles without any beat or register write before the run is abandoned.
    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        t_frac frac;
        t_pos  x;
        t_pos  y;
        t_pos  z;
        logic  last;
    } t_point;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    t_frac i_cfg_wr_data;

    tbc_pt_if  pt_if ();
    tbc_res_if res_if ();

    thresholded_bbox_centroid #(
        .MAX_POINTS (PT_LIMIT)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pt          (pt_if),
        .o_res         (res_if),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // Stimulus and expectation stores.
    t_point  pending_points[$];
    t_result expected_summaries[$];
    t_point  drv_point;
    t_result want;
    int      points_sent;
    int      points_accepted;
    int      mismatches;
    int      src_gap;
    int      snk_stall;
    bit      snk_stall_set;
    bit      src_idle_en;
    bit      snk_idle_en;
    int      quiet_cycles;

    // Bench copy of the block's state and its threshold register.
    t_frac              fill_thresh;
    t_pos               box_lo[3];
    t_pos               box_hi[3];
    logic signed [63:0] axis_sum[3];
    int unsigned        hits;

    // Clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void clear_running();
        for (int a = 0; a < 3; a++) begin
            box_lo[a]   = POS_MOST_POS;
            box_hi[a]   = POS_MOST_NEG;
            axis_sum[a] = '0;
        end
        hits = 0;
    endfunction

    // Fold one accepted point into the running state; a closing point also
    // queues the summary that the block should return for the set.
    function automatic void accumulate_point(t_point p);
        t_pos    c[3];
        t_result r;
        c[AXIS_X] = p.x;
        c[AXIS_Y] = p.y;
        c[AXIS_Z] = p.z;
        if (p.frac > fill_thresh) begin
            for (int a = 0; a < 3; a++) begin
                if (c[a] < box_lo[a]) box_lo[a] = c[a];
                if (c[a] > box_hi[a]) box_hi[a] = c[a];
            end
            // Once saturated, the box still grows but sums and count freeze.
            if (hits < PT_LIMIT) begin
                for (int a = 0; a < 3; a++) axis_sum[a] += c[a];
                hits++;
            end
        end
        if (p.last) begin
            r.box_min_x = box_lo[AXIS_X];
            r.box_max_x = box_hi[AXIS_X];
            r.box_min_y = box_lo[AXIS_Y];
            r.box_max_y = box_hi[AXIS_Y];
            r.box_min_z = box_lo[AXIS_Z];
            r.box_max_z = box_hi[AXIS_Z];
            r.mean_x = (hits == 0) ? '0 : t_pos'(axis_sum[AXIS_X] / $signed({32'd0, hits}));
            r.mean_y = (hits == 0) ? '0 : t_pos'(axis_sum[AXIS_Y] / $signed({32'd0, hits}));
            r.mean_z = (hits == 0) ? '0 : t_pos'(axis_sum[AXIS_Z] / $signed({32'd0, hits}));
            r.points_counted = t_count'(hits);
            expected_summaries.push_back(r);
            clear_running();
        end
    endfunction

    task automatic check_field(string name, logic signed [63:0] expv,
                               logic signed [63:0] actv);
        if (expv !== actv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            mismatches++;
        end
    endtask

    function automatic void push_point(t_frac f, t_pos x, t_pos y, t_pos z, bit last);
        t_point p;
        p.frac = f;
        p.x    = x;
        p.y    = y;
        p.z    = z;
        p.last = last;
        pending_points.push_back(p);
        points_sent++;
    endfunction

    function automatic t_pos rand_pos();
        case ($urandom_range(0, 5))
            0:       return POS_MOST_POS;
            1:       return POS_MOST_NEG;
            2:       return t_pos'($urandom_range(0, 4000)) - 32'sd2000;
            default: return t_pos'($urandom);
        endcase
    endfunction

    // Fractions cluster round the threshold; unless it is all ones, dense sets are all hits.
    function automatic t_frac rand_frac(bit dense);
        if (dense && fill_thresh != '1)
            return t_frac'($urandom_range(int'(fill_thresh) + 1, 131071));
        case ($urandom_range(0, 5))
            0:       return fill_thresh;
            1:       return fill_thresh + 1'b1;
            2:       return '0;
            3:       return 17'd65536;
            default: return t_frac'($urandom);
        endcase
    endfunction

    task automatic add_random_sets(int n_items);
        int left;
        int len;
        bit dense;
        left = n_items;
        while (left > 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(1, 4);
                6, 7:             len = $urandom_range(5, 12);
                default:          len = $urandom_range(13, 20);
            endcase
            dense = ($urandom_range(0, 2) == 0);
            for (int i = 0; i < len; i++)
                push_point(rand_frac(dense), rand_pos(), rand_pos(), rand_pos(),
                           i == len - 1);
            left -= len;
        end
    endtask

    // Wait until every point is taken and every summary has come back.
    task automatic drain();
        while (points_accepted != points_sent || expected_summaries.size() != 0)
            @(negedge i_clk);
        repeat (HOLD_OFF) @(negedge i_clk);
    endtask

    task automatic write_threshold(t_frac thr);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= thr;
        fill_thresh = thr;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(t_frac thr, int n_items, bit src_idle, bit snk_idle);
        drain();
        write_threshold(thr);
        src_idle_en = src_idle;
        snk_idle_en = snk_idle;
        add_random_sets(n_items);
    endtask

    // Point driver: holds a beat until it is taken, then waits its drawn gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt_if.valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (pt_if.valid && pt_if.ready) begin
                accumulate_point(drv_point);
                points_accepted++;
            end
            if (pt_if.valid && !pt_if.ready) begin
                // Beat still on offer.
            end else if (src_gap != 0) begin
                src_gap--;
                pt_if.valid <= 1'b0;
            end else if (pending_points.size() != 0) begin
                drv_point = pending_points.pop_front();
                pt_if.fill_fraction <= drv_point.frac;
                pt_if.pos_x         <= drv_point.x;
                pt_if.pos_y         <= drv_point.y;
                pt_if.pos_z         <= drv_point.z;
                pt_if.last_point    <= drv_point.last;
                pt_if.valid         <= 1'b1;
                src_gap = src_idle_en ? $urandom_range(0, 10) : 0;
            end else begin
                pt_if.valid <= 1'b0;
            end
        end
    end

    // Summary monitor: checks each beat taken and stalls for a drawn time.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            snk_stall     = 0;
            snk_stall_set = 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_summaries.size() == 0) begin
                    $error("summary beat arrived with none expected");
                    mismatches++;
                end else begin
                    want = expected_summaries.pop_front();
                    check_field("box_min_x", want.box_min_x, res_if.box_min_x);
                    check_field("box_max_x", want.box_max_x, res_if.box_max_x);
                    check_field("box_min_y", want.box_min_y, res_if.box_min_y);
                    check_field("box_max_y", want.box_max_y, res_if.box_max_y);
                    check_field("box_min_z", want.box_min_z, res_if.box_min_z);
                    check_field("box_max_z", want.box_max_z, res_if.box_max_z);
                    check_field("mean_x", want.mean_x, res_if.mean_x);
                    check_field("mean_y", want.mean_y, res_if.mean_y);
                    check_field("mean_z", want.mean_z, res_if.mean_z);
                    check_field("points_counted", {43'd0, want.points_counted},
                                {43'd0, res_if.points_counted});
                end
                snk_stall_set = 1'b0;
            end else if (res_if.valid && !snk_stall_set) begin
                snk_stall_set = 1'b1;
                snk_stall     = snk_idle_en ? $urandom_range(0, 10) : 0;
            end
            if (snk_stall_set) begin
                if (snk_stall != 0) begin
                    snk_stall--;
                    res_if.ready <= 1'b0;
                end else begin
                    res_if.ready <= 1'b1;
                end
            end else begin
                res_if.ready <= snk_idle_en ? 1'($urandom_range(0, 1)) : 1'b1;
            end
        end
    end

    // Watchdog on cycles in which nothing moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready)
            || i_cfg_wr_en) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("** thresholded_bbox_centroid: FAILED **");
                $finish;
            end
        end
    end

    // Main sequence.
    initial begin
        pt_if.valid         = 1'b0;
        pt_if.fill_fraction = '0;
        pt_if.pos_x         = '0;
        pt_if.pos_y         = '0;
        pt_if.pos_z         = '0;
        pt_if.last_point    = 1'b0;
        res_if.ready        = 1'b0;
        i_cfg_wr_en         = 1'b0;
        i_cfg_wr_data       = '0;
        i_rst_n             = 1'b0;
        points_sent         = 0;
        points_accepted     = 0;
        mismatches          = 0;
        quiet_cycles        = 0;
        src_idle_en         = 1'b1;
        snk_idle_en         = 1'b1;
        fill_thresh         = THRESH_RESET;
        clear_running();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed sets at the reset threshold of one half.
        // An empty set.
        push_point(17'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1);
        // A fraction equal to the threshold does not count; one above it does.
        push_point(17'd32768, 32'sd327680, 32'sd5, 32'sd5, 1'b0);
        push_point(17'd32769, 32'sd1, 32'sd2, 32'sd3, 1'b1);
        // Coordinate extremes, with a fraction that uses all 17 bits.
        push_point(17'd65536, POS_MOST_NEG, POS_MOST_POS, 32'sd0, 1'b0);
        push_point(17'd131071, POS_MOST_POS, POS_MOST_NEG, -32'sd1, 1'b1);
        // Negative sums truncate towards zero; the closing point does not count.
        push_point(17'd40000, -32'sd3, 32'sd7, -32'sd65536, 1'b0);
        push_point(17'd50000, 32'sd0, -32'sd2, -32'sd65537, 1'b0);
        push_point(17'd0, 32'sd99, 32'sd99, 32'sd99, 1'b1);
        // A longer set whose closing point sits at the extremes of every axis.
        for (int i = 0; i < 16; i++)
            push_point(17'd65536, t_pos'(i * 3 - 10), t_pos'(-i * 5), t_pos'(i), 1'b0);
        push_point(17'd65536, POS_MOST_POS, POS_MOST_NEG, POS_MOST_POS, 1'b1);

        // Random sets under a range of thresholds and idling patterns.
        run_phase(17'd0,      110, 1'b1, 1'b1);
        run_phase(17'd65536,   90, 1'b0, 1'b0);
        run_phase(17'd131071,  40, 1'b1, 1'b0);
        run_phase(t_frac'($urandom_range(1, 65535)), 120, 1'b1, 1'b0);
        run_phase(THRESH_RESET, 120, 1'b0, 1'b1);
        run_phase(t_frac'($urandom_range(1, 65535)), 80, 1'b1, 1'b1);

        drain();
        if (mismatches == 0) begin
            $display("** thresholded_bbox_centroid: PASSED **");
        end else begin
            $display("** thresholded_bbox_centroid: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/tbc_pkg.sv
sv/tbc_if.sv
sv/tbc_ctrl.sv
sv/tbc_datapath.sv
sv/thresholded_bbox_centroid.sv
sv/tbc_checker.sv
verif/tb.sv
